[hw/rtl/epb_pkg.sv]
// shared types, constants and helpers for the expiring pending buffer
package epb_pkg;

    localparam int ENTRIES      = 16;
    localparam int PAYLOAD_BITS = 64;
    localparam int IDX_W        = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int CNT_W        = $clog2(ENTRIES + 1);
    localparam int OCC_W        = 5;
    localparam int EXPIRY_W     = 31;
    localparam int TIME_W       = 32;
    localparam int DATA_W       = 64;
    localparam int APB_AW       = 2;
    localparam int APB_DW       = 32;

    localparam logic [EXPIRY_W-1:0] EXPIRY_RESET = EXPIRY_W'(30000);
    localparam logic [APB_AW-1:0]   ADDR_EXPIRY  = '0;

    localparam logic CMD_PUSH = 1'b0;
    localparam logic CMD_POP  = 1'b1;

    typedef struct packed {
        logic              command;
        logic [TIME_W-1:0] now_ms;
        logic [DATA_W-1:0] packet_data;
        logic              evictable;
    } epb_req_t;

    typedef struct packed {
        logic              ok;
        logic [DATA_W-1:0] popped_data;
        logic [OCC_W-1:0]  occupancy;
    } epb_rsp_t;

    // a lies strictly before b in wrapping time
    function automatic logic is_older(input logic [TIME_W-1:0] a,
                                      input logic [TIME_W-1:0] b);
        logic [TIME_W-1:0] diff;
        diff = a - b;
        return diff[TIME_W-1];
    endfunction

endpackage

[hw/rtl/expiring_pending_buffer.sv]
// expiring pending buffer: timestamped packet table with expiry, push and pop
//
//   channel | direction | handshake              | payload
//   req     | in        | req_valid / req_ready  | epb_req_t
//   rsp     | out       | rsp_valid / rsp_ready  | epb_rsp_t
//   apb     | in/out    | psel, penable, pready  | expiry_ms at address 0
//
// a request goes from acceptance to a valid response through a load state that
// starts the table read, a scan state that visits every entry in turn (expiry
// check on push, free slot search, oldest and oldest evictable search), a fetch
// state that reads the chosen entry and a write state that updates the table.
// req_ready is high only while idle; the response holds until rsp_ready.
// reset clears the used bits and the count and loads the expiry register with its reset value at once.
module expiring_pending_buffer (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          req_valid,
    output logic                          req_ready,
    input  epb_pkg::epb_req_t             req,
    output logic                          rsp_valid,
    input  logic                          rsp_ready,
    output epb_pkg::epb_rsp_t             rsp,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [epb_pkg::APB_AW-1:0]    paddr,
    input  logic [epb_pkg::APB_DW-1:0]    pwdata,
    output logic [epb_pkg::APB_DW-1:0]    prdata,
    output logic                          pready
);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_LOAD,
        ST_SCAN,
        ST_FETCH,
        ST_WRITE,
        ST_DONE
    } state_t;

    state_t                              state_reg;
    epb_pkg::epb_req_t                   req_reg;
    epb_pkg::epb_rsp_t                   rsp_reg;
    logic [epb_pkg::EXPIRY_W-1:0]        expiry_reg;
    logic [epb_pkg::ENTRIES-1:0]         slot_used_reg;
    logic [epb_pkg::CNT_W-1:0]           used_count_reg;
    logic [epb_pkg::IDX_W-1:0]           idx_reg;

    logic                                free_found_reg;
    logic [epb_pkg::IDX_W-1:0]           free_idx_reg;
    logic                                old_found_reg;
    logic [epb_pkg::IDX_W-1:0]           old_idx_reg;
    logic [epb_pkg::TIME_W-1:0]          old_created_reg;
    logic                                ev_found_reg;
    logic [epb_pkg::IDX_W-1:0]           ev_idx_reg;
    logic [epb_pkg::TIME_W-1:0]          ev_created_reg;

    logic [epb_pkg::TIME_W-1:0]          created_mem [epb_pkg::ENTRIES];
    logic [epb_pkg::TIME_W-1:0]          expires_mem [epb_pkg::ENTRIES];
    logic                                evict_mem   [epb_pkg::ENTRIES];
    logic [epb_pkg::PAYLOAD_BITS-1:0]    payload_mem [epb_pkg::ENTRIES];

    logic [epb_pkg::TIME_W-1:0]          rd_created_reg;
    logic [epb_pkg::TIME_W-1:0]          rd_expires_reg;
    logic                                rd_evict_reg;
    logic [epb_pkg::PAYLOAD_BITS-1:0]    rd_payload_reg;

    logic [epb_pkg::IDX_W-1:0]           rd_addr;
    logic                                cur_used;
    logic                                cur_expired;
    logic                                cur_alive;
    logic                                scan_last;
    logic                                is_push;
    logic [epb_pkg::IDX_W-1:0]           wr_idx;
    logic                                wr_en;
    logic [epb_pkg::CNT_W-1:0]           cnt_after;
    logic                                cfg_write;

    assign is_push     = (req_reg.command == epb_pkg::CMD_PUSH);
    assign cur_used    = slot_used_reg[idx_reg];
    assign cur_expired = is_push && cur_used
                         && !epb_pkg::is_older(req_reg.now_ms, rd_expires_reg);
    assign cur_alive   = cur_used && !cur_expired;
    assign scan_last   = (idx_reg == epb_pkg::IDX_W'(epb_pkg::ENTRIES - 1));

    always_comb
    begin
        unique case (state_reg)
            ST_LOAD:  rd_addr = '0;
            ST_SCAN:  rd_addr = epb_pkg::IDX_W'(idx_reg + 1'b1);
            default:  rd_addr = old_idx_reg;
        endcase
    end

    always_comb
    begin
        priority if (free_found_reg)
            wr_idx = free_idx_reg;
        else if (ev_found_reg)
            wr_idx = ev_idx_reg;
        else
            wr_idx = old_idx_reg;
    end

    always_comb
    begin
        cnt_after = used_count_reg;
        if (is_push)
        begin
            if (free_found_reg)
                cnt_after = epb_pkg::CNT_W'(used_count_reg + 1'b1);
        end
        else if (old_found_reg)
        begin
            cnt_after = epb_pkg::CNT_W'(used_count_reg - 1'b1);
        end
    end

    assign wr_en     = (state_reg == ST_WRITE) && is_push;
    assign cfg_write = psel && penable && pwrite && pready;

    // entry memory
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            created_mem[wr_idx] <= req_reg.now_ms;
            expires_mem[wr_idx] <= req_reg.now_ms
                                   + epb_pkg::TIME_W'(expiry_reg);
            evict_mem[wr_idx]   <= req_reg.evictable;
            payload_mem[wr_idx] <= req_reg.packet_data[epb_pkg::PAYLOAD_BITS-1:0];
        end
        rd_created_reg <= created_mem[rd_addr];
        rd_expires_reg <= expires_mem[rd_addr];
        rd_evict_reg   <= evict_mem[rd_addr];
        rd_payload_reg <= payload_mem[rd_addr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            expiry_reg     <= epb_pkg::EXPIRY_RESET;
            slot_used_reg  <= '0;
            used_count_reg <= '0;
            idx_reg        <= '0;
            free_found_reg <= 1'b0;
            old_found_reg  <= 1'b0;
            ev_found_reg   <= 1'b0;
        end
        else
        begin
            if (cfg_write && (paddr == epb_pkg::ADDR_EXPIRY))
                expiry_reg <= pwdata[epb_pkg::EXPIRY_W-1:0];

            unique case (state_reg)
                ST_IDLE:
                begin
                    if (req_valid)
                    begin
                        req_reg        <= req;
                        idx_reg        <= '0;
                        free_found_reg <= 1'b0;
                        old_found_reg  <= 1'b0;
                        ev_found_reg   <= 1'b0;
                        state_reg      <= ST_LOAD;
                    end
                end
                ST_LOAD:
                begin
                    state_reg <= ST_SCAN;
                end
                ST_SCAN:
                begin
                    if (cur_expired)
                    begin
                        slot_used_reg[idx_reg] <= 1'b0;
                        used_count_reg <= epb_pkg::CNT_W'(used_count_reg - 1'b1);
                    end
                    if (!cur_alive && !free_found_reg)
                    begin
                        free_found_reg <= 1'b1;
                        free_idx_reg   <= idx_reg;
                    end
                    if (cur_alive && (!old_found_reg
                        || epb_pkg::is_older(rd_created_reg, old_created_reg)))
                    begin
                        old_found_reg   <= 1'b1;
                        old_idx_reg     <= idx_reg;
                        old_created_reg <= rd_created_reg;
                    end
                    if (cur_alive && rd_evict_reg && (!ev_found_reg
                        || epb_pkg::is_older(rd_created_reg, ev_created_reg)))
                    begin
                        ev_found_reg   <= 1'b1;
                        ev_idx_reg     <= idx_reg;
                        ev_created_reg <= rd_created_reg;
                    end
                    if (scan_last)
                        state_reg <= ST_FETCH;
                    else
                        idx_reg <= epb_pkg::IDX_W'(idx_reg + 1'b1);
                end
                ST_FETCH:
                begin
                    state_reg <= ST_WRITE;
                end
                ST_WRITE:
                begin
                    used_count_reg        <= cnt_after;
                    rsp_reg.occupancy     <= epb_pkg::OCC_W'(cnt_after);
                    rsp_reg.popped_data   <= '0;
                    if (is_push)
                    begin
                        slot_used_reg[wr_idx] <= 1'b1;
                        rsp_reg.ok            <= 1'b1;
                    end
                    else
                    begin
                        rsp_reg.ok <= old_found_reg;
                        if (old_found_reg)
                        begin
                            slot_used_reg[old_idx_reg] <= 1'b0;
                            rsp_reg.popped_data <= epb_pkg::DATA_W'(rd_payload_reg);
                        end
                    end
                    state_reg <= ST_DONE;
                end
                ST_DONE:
                begin
                    if (rsp_ready)
                        state_reg <= ST_IDLE;
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    assign req_ready = (state_reg == ST_IDLE);
    assign rsp_valid = (state_reg == ST_DONE);
    assign rsp       = rsp_reg;
    assign pready    = 1'b1;
    assign prdata    = (paddr == epb_pkg::ADDR_EXPIRY)
                       ? epb_pkg::APB_DW'(expiry_reg) : '0;

`ifndef SYNTHESIS
    a_count_matches_used: assert property (@(posedge clk) disable iff (!rst_n)
        32'(used_count_reg) == $countones(slot_used_reg))
        else $error("occupancy count disagrees with used bits");

    a_ready_excludes_rsp: assert property (@(posedge clk) disable iff (!rst_n)
        req_ready |-> !rsp_valid)
        else $error("request taken while a response is pending");

    a_failed_pop_empty: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid && !rsp.ok) |-> (rsp.popped_data == '0 && rsp.occupancy == '0))
        else $error("failed pop with data or nonzero occupancy");

    a_accept_starts_scan: assert property (@(posedge clk) disable iff (!rst_n)
        (req_valid && req_ready) |=> (state_reg == ST_LOAD && idx_reg == '0))
        else $error("accepted request did not start the scan");
`endif

endmodule
